// ===== hw/rtl/ord_pkg.sv =====
// shared types, codes and record checks for the object record deframer
`default_nettype none

package ord_pkg;

    localparam logic [15:0] ORD_MAX_LEN_RESET = 16'd4096;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NORMEND  = 3'd1;
    localparam logic [2:0] ST_PREMEND  = 3'd2;
    localparam logic [2:0] ST_BADSUM   = 3'd3;
    localparam logic [2:0] ST_BADTYPE  = 3'd4;
    localparam logic [2:0] ST_BADLEN   = 3'd5;
    localparam logic [2:0] ST_SPURIOUS = 3'd6;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [7:0] TYPE_LO1_MIN = 8'h02;
    localparam logic [7:0] TYPE_LO1_MAX = 8'h2E;
    localparam logic [7:0] TYPE_LO2_MIN = 8'h6E;
    localparam logic [7:0] TYPE_LO2_MAX = 8'hCE;
    localparam logic [7:0] TYPE_END_A   = 8'h0E;
    localparam logic [7:0] TYPE_END_B   = 8'h8A;
    localparam logic [7:0] TYPE_END_C   = 8'hAA;

    typedef struct packed {
        logic        kind;
        logic [7:0]  pbyte;
        logic [15:0] pindex;
        logic [2:0]  status;
        logic [7:0]  rtype;
        logic [15:0] rlength;
    } t_result;

    function automatic logic type_valid(input logic [7:0] t);
        type_valid = !t[0] && (t inside {[TYPE_LO1_MIN:TYPE_LO1_MAX],
                                         [TYPE_LO2_MIN:TYPE_LO2_MAX]});
    endfunction

    function automatic logic type_is_end(input logic [7:0] t);
        type_is_end = t inside {TYPE_END_A, TYPE_END_B, TYPE_END_C};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/object_record_deframer_core.sv =====
// object record deframer top level: config register, parser and output register
// a result is registered and on the outputs in the cycle after its word is accepted
// one word per cycle while o_in_stall is low; the header/body state update and the output
//   register are each a single registered pass
// input stall rises only while a result waits and the output side stalls
// synchronous active-low reset: parser waits for a type byte, max length 4096
`default_nettype none

module object_record_deframer_core import ord_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_stream_byte,
    input  wire logic        i_end_of_stream,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_out_kind,
    output logic [7:0]       o_payload_byte,
    output logic [15:0]      o_payload_index,
    output logic [2:0]       o_status,
    output logic [7:0]       o_record_type,
    output logic [15:0]      o_record_length
);

    logic [15:0] r_max_len;
    logic        r_out_valid;
    t_result     r_out;

    logic        out_free;
    logic        accept;
    logic        res_valid;
    t_result     res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign accept     = i_in_valid && out_free;
    assign o_in_stall = !out_free;

    ord_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_stream_byte),
        .i_eos       (i_end_of_stream),
        .i_max_len   (r_max_len),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= ORD_MAX_LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
            if (out_free) begin
                r_out_valid <= accept && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && accept && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_kind      = r_out.kind;
    assign o_payload_byte  = r_out.pbyte;
    assign o_payload_index = r_out.pindex;
    assign o_status        = r_out.status;
    assign o_record_type   = r_out.rtype;
    assign o_record_length = r_out.rlength;

endmodule

`default_nettype wire

// ===== hw/rtl/ord_engine.sv =====
// record parse state machine: header, body, checksum and framing checks
`default_nettype none

module ord_engine import ord_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_eos,
    input  wire logic [15:0] i_max_len,
    output t_result          o_res,
    output logic             o_res_valid
);

    localparam logic [2:0] PH_TYPE   = 3'd0;
    localparam logic [2:0] PH_LEN_LO = 3'd1;
    localparam logic [2:0] PH_LEN_HI = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_HALT   = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_len, n_len;
    logic [15:0] r_seen, n_seen;
    logic [7:0]  r_sum, n_sum;
    logic        r_end_seen, n_end_seen;

    logic [7:0]  sum_add;
    logic [15:0] len_full;
    logic [15:0] seen_inc;

    assign sum_add  = r_sum + i_byte;
    assign len_full = {i_byte, r_len[7:0]};
    assign seen_inc = r_seen + 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_len       = r_len;
        n_seen      = r_seen;
        n_sum       = r_sum;
        n_end_seen  = r_end_seen;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_STATUS, pbyte: 8'd0, pindex: 16'd0,
                        status: ST_OK, rtype: r_type, rlength: r_len};
        if (i_accept) begin
            case (r_phase)
                PH_TYPE: begin
                    if (i_eos) begin
                        o_res_valid   = 1'b1;
                        o_res.status  = ST_NORMEND;
                        o_res.rtype   = 8'd0;
                        o_res.rlength = 16'd0;
                        n_phase       = PH_HALT;
                    end else if (!type_valid(i_byte)) begin
                        o_res_valid   = 1'b1;
                        o_res.status  = r_end_seen ? ST_SPURIOUS : ST_BADTYPE;
                        o_res.rtype   = i_byte;
                        o_res.rlength = 16'd0;
                        n_phase       = PH_HALT;
                    end else begin
                        n_type  = i_byte;
                        n_len   = 16'd0;
                        n_seen  = 16'd0;
                        n_sum   = i_byte;
                        n_phase = PH_LEN_LO;
                    end
                end
                PH_LEN_LO: begin
                    if (i_eos) begin
                        o_res_valid  = 1'b1;
                        o_res.status = r_end_seen ? ST_SPURIOUS : ST_BADLEN;
                        n_phase      = PH_HALT;
                    end else begin
                        n_len   = {8'd0, i_byte};
                        n_sum   = sum_add;
                        n_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    if (i_eos) begin
                        o_res_valid  = 1'b1;
                        o_res.status = r_end_seen ? ST_SPURIOUS : ST_BADLEN;
                        n_phase      = PH_HALT;
                    end else begin
                        n_len         = len_full;
                        n_sum         = sum_add;
                        n_seen        = 16'd0;
                        o_res.rlength = len_full;
                        if (len_full > i_max_len) begin
                            o_res_valid  = 1'b1;
                            o_res.status = r_end_seen ? ST_SPURIOUS : ST_BADLEN;
                            n_phase      = PH_HALT;
                        end else if (len_full == 16'd0) begin
                            // empty record closes at once, sum cannot be zero
                            o_res_valid  = 1'b1;
                            o_res.status = (sum_add == 8'd0) ? ST_OK : ST_BADSUM;
                            n_end_seen   = type_is_end(r_type);
                            n_phase      = PH_TYPE;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    o_res_valid = 1'b1;
                    if (i_eos) begin
                        o_res.status = r_end_seen ? ST_SPURIOUS : ST_PREMEND;
                        n_phase      = PH_HALT;
                    end else begin
                        n_sum  = sum_add;
                        n_seen = seen_inc;
                        if (seen_inc >= r_len) begin
                            // last byte is the checksum
                            o_res.status = (sum_add == 8'd0) ? ST_OK : ST_BADSUM;
                            n_end_seen   = type_is_end(r_type);
                            n_phase      = PH_TYPE;
                        end else begin
                            o_res.kind   = KIND_PAYLOAD;
                            o_res.pbyte  = i_byte;
                            o_res.pindex = r_seen;
                        end
                    end
                end
                default: begin
                    // halted until reset
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TYPE;
            r_type     <= 8'd0;
            r_len      <= 16'd0;
            r_seen     <= 16'd0;
            r_sum      <= 8'd0;
            r_end_seen <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_type     <= n_type;
            r_len      <= n_len;
            r_seen     <= n_seen;
            r_sum      <= n_sum;
            r_end_seen <= n_end_seen;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ord_checker.sv =====
// port-level checks for the object record deframer, bound to the top level
`default_nettype none

module ord_checker import ord_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_out_kind,
    input wire logic [7:0]  o_payload_byte,
    input wire logic [15:0] o_payload_index,
    input wire logic [2:0]  o_status,
    input wire logic [7:0]  o_record_type,
    input wire logic [15:0] o_record_length
);

    logic out_take;
    logic halting;

    assign out_take = o_out_valid && !i_out_stall;
    assign halting  = o_out_kind == KIND_STATUS &&
                      (o_status == ST_NORMEND || o_status == ST_PREMEND ||
                       o_status == ST_BADTYPE || o_status == ST_BADLEN ||
                       o_status == ST_SPURIOUS);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
        $stable(o_out_kind) && $stable(o_payload_byte) && $stable(o_payload_index) &&
        $stable(o_record_type) && $stable(o_record_length))
        else $error("stalled output word changed");

    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_PAYLOAD |-> o_status == ST_OK)
        else $error("payload word carries a nonzero status");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_STATUS |->
        o_payload_byte == 8'd0 && o_payload_index == 16'd0)
        else $error("status word carries payload fields");

    // after a stopping status nothing more comes out
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && halting |=> !o_out_valid)
        else $error("output after a stopping status");

endmodule

bind object_record_deframer_core ord_checker u_ord_checker (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for the object record deframer: directed and random record streams
`default_nettype none

module tb_top;
    import ord_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int N_DIRECTED     = 22;

    typedef enum logic [2:0] {
        PARSE_TYPE,
        PARSE_LEN_LO,
        PARSE_LEN_HI,
        PARSE_BODY,
        PARSE_HALTED
    } t_parse_phase;

    typedef struct {
        logic [7:0] sbyte;
        logic       eos;
        bit         typed;
        t_result    want;
    } t_stim_row;

    localparam t_result NO_WORD = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_stream_byte = '0;
    logic        i_end_of_stream = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_out_kind;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_payload_index;
    logic [2:0]  o_status;
    logic [7:0]  o_record_type;
    logic [15:0] o_record_length;

    // parser copy used for prediction
    t_parse_phase parse_phase = PARSE_TYPE;
    logic [7:0]   cur_type = '0;
    logic [15:0]  cur_length = '0;
    logic [15:0]  body_count = '0;
    logic [7:0]   byte_sum = '0;
    bit           after_end_record = 1'b0;
    logic [15:0]  max_len_model = ORD_MAX_LEN_RESET;

    t_result      deframed_q [$];
    t_result      oldest;
    t_stim_row    directed_rows [N_DIRECTED];
    int unsigned  mismatch_count = 0;
    int unsigned  words_sent = 0;
    bit           idling_on = 1'b1;
    bit           hold_request = 1'b0;
    int           hold_left = 0;
    int           stall_left = 0;

    // the first four are range bounds, the last three are end record types
    logic [7:0] corner_types [7] = '{TYPE_LO1_MIN, TYPE_LO1_MAX, TYPE_LO2_MIN, TYPE_LO2_MAX,
                                     TYPE_END_A, TYPE_END_B, TYPE_END_C};

    object_record_deframer_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_stream_byte   (i_stream_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_kind      (o_out_kind),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_status        (o_status),
        .o_record_type   (o_record_type),
        .o_record_length (o_record_length)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit legal_type(input logic [7:0] t);
        return !t[0] && ((t >= TYPE_LO1_MIN && t <= TYPE_LO1_MAX) ||
                         (t >= TYPE_LO2_MIN && t <= TYPE_LO2_MAX));
    endfunction

    function automatic bit closing_type(input logic [7:0] t);
        return t == TYPE_END_A || t == TYPE_END_B || t == TYPE_END_C;
    endfunction

    // advances the parser copy by one word, returns 1 when a result word is due
    function automatic bit deframe_word(input logic [7:0] b, input logic eos,
                                        output t_result res);
        bit         framing_fault;
        bit         record_done;
        logic [2:0] fault_code;
        framing_fault = 1'b0;
        record_done = 1'b0;
        fault_code = ST_OK;
        res = '0;
        res.kind = KIND_STATUS;
        case (parse_phase)
            PARSE_TYPE: begin
                if (eos) begin
                    res.status = ST_NORMEND;
                    parse_phase = PARSE_HALTED;
                    return 1'b1;
                end else if (!legal_type(b)) begin
                    framing_fault = 1'b1;
                    fault_code = ST_BADTYPE;
                end else begin
                    cur_type = b;
                    cur_length = '0;
                    body_count = '0;
                    byte_sum = b;
                    parse_phase = PARSE_LEN_LO;
                end
            end
            PARSE_LEN_LO: begin
                if (eos) begin
                    framing_fault = 1'b1;
                    fault_code = ST_BADLEN;
                end else begin
                    cur_length = {8'h00, b};
                    byte_sum += b;
                    parse_phase = PARSE_LEN_HI;
                end
            end
            PARSE_LEN_HI: begin
                if (eos) begin
                    framing_fault = 1'b1;
                    fault_code = ST_BADLEN;
                end else begin
                    cur_length[15:8] = b;
                    byte_sum += b;
                    if (cur_length > max_len_model) begin
                        framing_fault = 1'b1;
                        fault_code = ST_BADLEN;
                    end else begin
                        body_count = '0;
                        if (cur_length == 0)
                            record_done = 1'b1;
                        else
                            parse_phase = PARSE_BODY;
                    end
                end
            end
            PARSE_BODY: begin
                if (eos) begin
                    framing_fault = 1'b1;
                    fault_code = ST_PREMEND;
                end else begin
                    byte_sum += b;
                    body_count += 16'd1;
                    if (body_count >= cur_length) begin
                        record_done = 1'b1;
                    end else begin
                        res.kind = KIND_PAYLOAD;
                        res.pbyte = b;
                        res.pindex = body_count - 16'd1;
                        res.rtype = cur_type;
                        res.rlength = cur_length;
                        return 1'b1;
                    end
                end
            end
            default: return 1'b0;
        endcase
        if (framing_fault) begin
            res.status = after_end_record ? ST_SPURIOUS : fault_code;
            // a bad type reports the offending byte and no length
            res.rtype = (fault_code == ST_BADTYPE) ? b : cur_type;
            res.rlength = (fault_code == ST_BADTYPE) ? 16'h0000 : cur_length;
            parse_phase = PARSE_HALTED;
            return 1'b1;
        end
        if (record_done) begin
            after_end_record = closing_type(cur_type);
            res.status = (byte_sum == 0) ? ST_OK : ST_BADSUM;
            res.rtype = cur_type;
            res.rlength = cur_length;
            parse_phase = PARSE_TYPE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 3))
            0: return corner_types[$urandom_range(0, 6)];
            1: return 8'($urandom_range(1, 23) * 2);
            default: return 8'($urandom_range(55, 103) * 2);
        endcase
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eos, input bit typed,
                             input t_result want);
        t_result res;
        bit      got;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            i_stream_byte = 8'($urandom);
            i_end_of_stream = 1'($urandom);
            repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_stream_byte = b;
        i_end_of_stream = eos;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        got = deframe_word(b, eos, res);
        if (typed)
            deframed_q.push_back(want);
        else if (got)
            deframed_q.push_back(res);
    endtask

    task automatic send_record(input logic [7:0] rtype, input logic [15:0] len,
                               input bit good_sum);
        logic [7:0] sum;
        logic [7:0] b;
        sum = rtype + len[7:0] + len[15:8];
        send_word(rtype, 1'b0, 1'b0, NO_WORD);
        send_word(len[7:0], 1'b0, 1'b0, NO_WORD);
        send_word(len[15:8], 1'b0, 1'b0, NO_WORD);
        for (int i = 1; i < int'(len); i++) begin
            b = 8'($urandom);
            sum += b;
            send_word(b, 1'b0, 1'b0, NO_WORD);
        end
        if (len != 0)
            send_word(good_sum ? 8'(8'h00 - sum) : 8'($urandom), 1'b0, 1'b0, NO_WORD);
    endtask

    // only while idle: input dropped and every expected word drained
    task automatic set_max_length(input logic [15:0] v);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        max_len_model = v;
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (deframed_q.size() == 0) begin
                $error("result word with none expected: kind %0d status %0d",
                       o_out_kind, o_status);
                mismatch_count++;
            end else begin
                oldest = deframed_q.pop_front();
                compare_field("out_kind", oldest.kind, o_out_kind);
                compare_field("payload_byte", oldest.pbyte, o_payload_byte);
                compare_field("payload_index", oldest.pindex, o_payload_index);
                compare_field("status", oldest.status, o_status);
                compare_field("record_type", oldest.rtype, o_record_type);
                compare_field("record_length", oldest.rlength, o_record_length);
            end
        end
    end

    // output side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall = 1'b1;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int unsigned m;
        logic [15:0] len;
        logic [7:0]  t;
        directed_rows = '{
            // min type, zero length: closes at once with a bad sum
            '{8'h02, 1'b0, 1'b0, NO_WORD},
            '{8'h00, 1'b0, 1'b0, NO_WORD},
            '{8'h00, 1'b0, 1'b1, '{KIND_STATUS, 8'h00, 16'h0000, ST_BADSUM, 8'h02, 16'h0000}},
            // max type, checksum only
            '{8'hCE, 1'b0, 1'b0, NO_WORD},
            '{8'h01, 1'b0, 1'b0, NO_WORD},
            '{8'h00, 1'b0, 1'b0, NO_WORD},
            '{8'h31, 1'b0, 1'b1, '{KIND_STATUS, 8'h00, 16'h0000, ST_OK, 8'hCE, 16'h0001}},
            // low bound of upper range, payload extremes
            '{8'h6E, 1'b0, 1'b0, NO_WORD},
            '{8'h03, 1'b0, 1'b0, NO_WORD},
            '{8'h00, 1'b0, 1'b0, NO_WORD},
            '{8'hFF, 1'b0, 1'b1, '{KIND_PAYLOAD, 8'hFF, 16'h0000, ST_OK, 8'h6E, 16'h0003}},
            '{8'h00, 1'b0, 1'b0, NO_WORD},
            '{8'h90, 1'b0, 1'b1, '{KIND_STATUS, 8'h00, 16'h0000, ST_OK, 8'h6E, 16'h0003}},
            // top of lower range, bad checksum
            '{8'h2E, 1'b0, 1'b0, NO_WORD},
            '{8'h02, 1'b0, 1'b0, NO_WORD},
            '{8'h00, 1'b0, 1'b0, NO_WORD},
            '{8'hAA, 1'b0, 1'b0, NO_WORD},
            '{8'h00, 1'b0, 1'b1, '{KIND_STATUS, 8'h00, 16'h0000, ST_BADSUM, 8'h2E, 16'h0002}},
            // end record followed by more records
            '{8'h0E, 1'b0, 1'b0, NO_WORD},
            '{8'h01, 1'b0, 1'b0, NO_WORD},
            '{8'h00, 1'b0, 1'b0, NO_WORD},
            '{8'hF1, 1'b0, 1'b1, '{KIND_STATUS, 8'h00, 16'h0000, ST_OK, 8'h0E, 16'h0001}}
        };
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r])
            send_word(directed_rows[r].sbyte, directed_rows[r].eos, directed_rows[r].typed,
                      directed_rows[r].want);

        // with no length allowed only empty records pass the length check
        set_max_length(16'h0000);
        repeat (8) send_record(pick_type(), 16'h0000, 1'b1);

        set_max_length(16'hFFFF);
        send_record(pick_type(), 16'd12, 1'b1);
        // output held off during a long record so the input backs up
        hold_request = 1'b1;
        send_record(pick_type(), 16'd260, 1'b1);
        while (words_sent < 330)
            send_record(pick_type(), 16'($urandom_range(0, 16)), $urandom_range(0, 3) != 0);

        m = $urandom_range(1, 40);
        set_max_length(16'(m));
        while (words_sent < 450) begin
            if (words_sent >= 380)
                idling_on = 1'b0;
            len = ($urandom_range(0, 3) == 0) ? 16'(m) : 16'($urandom_range(0, m));
            send_record(pick_type(), len, $urandom_range(0, 3) != 0);
        end

        // one stream-ending case, sometimes after an end record so it reads as spurious
        if ($urandom_range(0, 1) == 1)
            send_record(corner_types[4 + $urandom_range(0, 2)], 16'($urandom_range(0, m)),
                        1'b1);
        t = pick_type();
        case ($urandom_range(0, 5))
            0: send_word(8'($urandom), 1'b1, 1'b0, NO_WORD);
            1: begin
                do t = 8'($urandom); while (legal_type(t));
                send_word(t, 1'b0, 1'b0, NO_WORD);
            end
            2: begin
                send_word(t, 1'b0, 1'b0, NO_WORD);
                send_word(8'($urandom), 1'b1, 1'b0, NO_WORD);
            end
            3: begin
                send_word(t, 1'b0, 1'b0, NO_WORD);
                send_word(8'($urandom), 1'b0, 1'b0, NO_WORD);
                send_word(8'($urandom), 1'b1, 1'b0, NO_WORD);
            end
            4: begin
                len = 16'($urandom_range(m + 1, 65535));
                send_word(t, 1'b0, 1'b0, NO_WORD);
                send_word(len[7:0], 1'b0, 1'b0, NO_WORD);
                send_word(len[15:8], 1'b0, 1'b0, NO_WORD);
            end
            default: begin
                len = 16'($urandom_range(1, m));
                send_word(t, 1'b0, 1'b0, NO_WORD);
                send_word(len[7:0], 1'b0, 1'b0, NO_WORD);
                send_word(len[15:8], 1'b0, 1'b0, NO_WORD);
                repeat ($urandom_range(0, len - 1))
                    send_word(8'($urandom), 1'b0, 1'b0, NO_WORD);
                send_word(8'($urandom), 1'b1, 1'b0, NO_WORD);
            end
        endcase
        // halted: these words must give nothing
        repeat (6) send_word(8'($urandom), 1'($urandom), 1'b0, NO_WORD);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== object_record_deframer_core.f =====
hw/rtl/ord_pkg.sv
hw/rtl/ord_engine.sv
hw/rtl/object_record_deframer_core.sv
hw/rtl/ord_checker.sv
dv/tb_top.sv
